FILE: rtl/commutation_period_to_reload_defines.svh
// Assertion macros for the commutation period to reload block.
`ifndef COMMUTATION_PERIOD_TO_RELOAD_DEFINES_SVH
`define COMMUTATION_PERIOD_TO_RELOAD_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cpr_pkg.sv
// Shared types and constants of the commutation period to reload block.
`timescale 1ns / 1ps
package cpr_pkg;
    localparam int PERIOD_W = 32;
    localparam int CLK_W    = 27;               // timer clock, bus clock doubled
    localparam int DIV_W    = 17;               // prescaler plus one
    localparam int DEN_W    = 36;               // 1e6 * (prescaler + 1)
    localparam int PROD_W   = PERIOD_W + CLK_W; // period * timer clock
    localparam int QUO_W    = 17;               // ticks never exceed 65536
    localparam int NUM_W    = DEN_W + 16;       // 65536 * denominator

    localparam logic [19:0]          US_PER_S   = 20'd1000000;
    localparam logic [PERIOD_W-1:0]  PERIOD_SAT = 32'hFFFF_FFFF;
    localparam logic [PERIOD_W-1:0]  MIN_PERIOD = 32'd50;
    localparam logic [15:0]          RELOAD_MAX = 16'hFFFF;

    localparam logic [1:0] REG_BUS_CLOCK = 2'd0;
    localparam logic [1:0] REG_BUS_DIV   = 2'd1;
    localparam logic [1:0] REG_PRESCALER = 2'd2;

    typedef struct packed {
        logic                busy;
        logic [PERIOD_W-1:0] bound;
    } t_bound_status;
endpackage

FILE: rtl/cpr_div_stage.sv
// One restoring step of the pipelined tick divider.
`timescale 1ns / 1ps
module cpr_div_stage #(
    parameter int SHIFT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_valid,
    input  logic [cpr_pkg::PROD_W-1:0]  i_rem,
    input  logic [cpr_pkg::QUO_W-1:0]   i_quo,
    input  logic [cpr_pkg::DEN_W-1:0]   i_denom,
    output logic                        o_valid,
    output logic [cpr_pkg::PROD_W-1:0]  o_rem,
    output logic [cpr_pkg::QUO_W-1:0]   o_quo
);
    import cpr_pkg::*;

    logic [PROD_W-1:0] w_sub;
    logic              w_ge;
    logic              r_valid;
    logic [PROD_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;

    assign w_sub = PROD_W'(i_denom) << SHIFT;
    assign w_ge  = (i_rem >= w_sub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
        if (i_advance) begin
            r_rem <= w_ge ? (i_rem - w_sub) : i_rem;
            r_quo <= {i_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
endmodule

FILE: rtl/cpr_bound_div.sv
// Iterative divider for the longest reachable period, one bit a cycle.
`timescale 1ns / 1ps
module cpr_bound_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cpr_pkg::CLK_W-1:0]   i_tclk,
    input  logic [cpr_pkg::DIV_W-1:0]   i_div,
    output cpr_pkg::t_bound_status      o_status
);
    import cpr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0]    r_num;
    logic [CLK_W:0]      r_rem;
    logic [NUM_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;

    logic [CLK_W:0]      w_rem_sh;
    logic                w_ge;
    logic [DEN_W-1:0]    w_denom;

    assign w_denom  = DEN_W'(i_div) * DEN_W'(US_PER_S);
    assign w_rem_sh = {r_rem[CLK_W-1:0], r_num[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, i_tclk});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_num <= {w_denom, 16'b0};
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? (w_rem_sh - {1'b0, i_tclk}) : w_rem_sh;
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    // saturate to 32 bits; a zero clock ends up all ones as well.
    // Taken straight from the quotient so it is ready as busy drops.
    assign o_status.busy  = r_busy;
    assign o_status.bound = (|r_quo[NUM_W-1:PERIOD_W] || i_tclk == '0) ? PERIOD_SAT
                                                                       : r_quo[PERIOD_W-1:0];
endmodule

FILE: rtl/commutation_period_to_reload.sv
// Top level: commutation period in microseconds to 16-bit timer reload value.
//
// Usage
//   Input channel: i_valid / o_stall carry one request, i_req_period.
//   Output channel: o_valid / i_stall carry one result, o_reload_value.
//   A request is taken at a clock edge with valid high and stall low.
//   APB port sets bus clock (0x0), bus divided flag (0x4), prescaler (0x8).
// Timing
//   One request a cycle while o_stall is low. Stages in order: clamp,
//   multiply, 17 divider steps (one quotient bit each), reload saturation.
//   After reset and after every register write the period bound is redone
//   by a bit-serial divider: o_stall stays high until it is done.
// Reset
//   Synchronous, active low. Registers take their defaults (64 MHz, not
//   divided, prescaler 63), the pipeline empties, the bound is redone.
// Stall
//   When a result waits under i_stall the whole pipeline holds and
//   o_stall rises; nothing is dropped or repeated.
`timescale 1ns / 1ps
module commutation_period_to_reload (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_req_period,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_reload_value
);
    import cpr_pkg::*;
    `include "commutation_period_to_reload_defines.svh"

    localparam int NSTG = QUO_W;

    // configuration registers
    logic [25:0] r_bus_clock;
    logic        r_bus_div;
    logic [15:0] r_presc;
    logic        r_recalc;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_clock <= 26'd64000000;
            r_bus_div   <= 1'b0;
            r_presc     <= 16'd63;
            r_recalc    <= 1'b1;
        end else begin
            r_recalc <= w_wr;
            if (w_wr) begin
                case (paddr[3:2])
                    REG_BUS_CLOCK: r_bus_clock <= pwdata[25:0];
                    REG_BUS_DIV:   r_bus_div   <= pwdata[0];
                    REG_PRESCALER: r_presc     <= pwdata[15:0];
                    default:       ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BUS_CLOCK: prdata = {6'b0, r_bus_clock};
            REG_BUS_DIV:   prdata = {31'b0, r_bus_div};
            REG_PRESCALER: prdata = {16'b0, r_presc};
            default:       prdata = '0;
        endcase
    end

    // derived operands: timer clock and 1e6 * (prescaler + 1)
    logic [CLK_W-1:0] w_tclk;
    logic [DIV_W-1:0] w_div;
    logic [DEN_W-1:0] r_denom;

    assign w_tclk = r_bus_div ? {r_bus_clock, 1'b0} : {1'b0, r_bus_clock};
    assign w_div  = DIV_W'(r_presc) + 1'b1;

    always_ff @(posedge i_clk) begin
        r_denom <= DEN_W'(w_div) * DEN_W'(US_PER_S);
    end

    // period bound, redone after reset and every write
    t_bound_status w_bound_st;

    cpr_bound_div u_bound (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_recalc),
        .i_tclk   (w_tclk),
        .i_div    (w_div),
        .o_status (w_bound_st)
    );

    // pipeline control: one global advance
    logic w_advance;
    logic w_accept;
    logic r_o_valid;

    assign w_advance = !r_o_valid || !i_stall;
    assign o_stall   = r_recalc || w_bound_st.busy || !w_advance;
    assign w_accept  = i_valid && !o_stall;

    // stage A: clamp to bound then to the minimum
    logic [PERIOD_W-1:0] w_clamp;
    logic [PERIOD_W-1:0] w_clamp_hi;
    logic                r_a_valid;
    logic [PERIOD_W-1:0] r_a_period;

    assign w_clamp_hi = (i_req_period > w_bound_st.bound) ? w_bound_st.bound : i_req_period;
    assign w_clamp    = (w_clamp_hi < MIN_PERIOD) ? MIN_PERIOD : w_clamp_hi;

    // stage B: period * timer clock
    logic              r_b_valid;
    logic [PROD_W-1:0] r_b_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (w_advance) begin
            r_a_valid <= w_accept;
            r_b_valid <= r_a_valid;
        end
        if (w_advance) begin
            r_a_period <= w_clamp;
            r_b_prod   <= PROD_W'(r_a_period) * PROD_W'(w_tclk);
        end
    end

    // divider chain: ticks = floor(prod / denom), MSB first
    logic              w_sv [NSTG+1];
    logic [PROD_W-1:0] w_sr [NSTG+1];
    logic [QUO_W-1:0]  w_sq [NSTG+1];

    assign w_sv[0] = r_b_valid;
    assign w_sr[0] = r_b_prod;
    assign w_sq[0] = '0;

    for (genvar g = 0; g < NSTG; g++) begin : g_div
        cpr_div_stage #(
            .SHIFT (NSTG - 1 - g)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_valid   (w_sv[g]),
            .i_rem     (w_sr[g]),
            .i_quo     (w_sq[g]),
            .i_denom   (r_denom),
            .o_valid   (w_sv[g+1]),
            .o_rem     (w_sr[g+1]),
            .o_quo     (w_sq[g+1])
        );
    end

    // output stage: reload = ticks - 1, zero stays zero, saturated
    logic [QUO_W-1:0] w_ticks;
    logic [QUO_W-1:0] w_dec;
    logic [15:0]      r_reload;

    assign w_ticks = w_sq[NSTG];
    assign w_dec   = (w_ticks == '0) ? '0 : (w_ticks - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_advance) begin
            r_o_valid <= w_sv[NSTG];
        end
        if (w_advance) begin
            r_reload <= w_dec[QUO_W-1] ? RELOAD_MAX : w_dec[15:0];
        end
    end

    assign o_valid        = r_o_valid;
    assign o_reload_value = r_reload;

    `CPR_ASSERT_IMP(a_busy_blocks, i_clk, i_rst_n, w_bound_st.busy, o_stall,
        "request taken while bound is recomputed")
    `CPR_ASSERT_NXT(a_write_recalc, i_clk, i_rst_n, w_wr, r_recalc,
        "register write did not start bound recompute")
    `CPR_ASSERT_NXT(a_recalc_busy, i_clk, i_rst_n, r_recalc, w_bound_st.busy,
        "bound divider did not start")
endmodule
